[hw/rtl/fuel_level_alarm_monitor_defines.svh]
// Assertion macros shared by the fuel level alarm monitor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FUEL_LEVEL_ALARM_MONITOR_DEFINES_SVH
`define FUEL_LEVEL_ALARM_MONITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FLAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flam assertion failed");

// Next-cycle implication, checked outside reset.
`define FLAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flam assertion failed");

`endif

[hw/rtl/flam_pkg.sv]
// Shared types and constants for the fuel level alarm monitor.
// No dependencies; used by every module of the block.
package flam_pkg;

    localparam int unsigned LEVEL_W  = 14;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LIMIT_W  = 36;
    localparam int unsigned SPAN_W   = LEVEL_W + TIME_W;
    localparam int unsigned CIDX_W   = 3;
    localparam int unsigned CDATA_W  = 14;

    // Sixty minutes in milliseconds: the time-left threshold.
    localparam logic [21:0] ETA_LIMIT_MS = 22'd3600000;

    typedef enum logic [CIDX_W-1:0] {
        REG_MIN_LEVEL   = 3'd0,
        REG_RESERVE     = 3'd1,
        REG_OFF_LEVEL   = 3'd2,
        REG_SENSITIVITY = 3'd3,
        REG_ENABLE      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] reserve_level;
        logic [LEVEL_W-1:0] off_level;
        logic [LEVEL_W-1:0] step_sensitivity;
        logic               monitor_enable;
        logic [LIMIT_W-1:0] eta_limit;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_out;
        logic               rate_alarm;
        logic               low_alarm;
        logic               machine_off;
        logic [TIME_W-1:0]  empty_interval;
    } result_t;

endpackage

[hw/rtl/flam_cfg.sv]
// Configuration register file of the fuel level alarm monitor.
// Depends on flam_pkg; also keeps the precomputed time-left limit.
module flam_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [flam_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [flam_pkg::CDATA_W-1:0]      cfg_data,
    output flam_pkg::cfg_t                    cfg
);

    flam_pkg::cfg_t cfg_reg;
    flam_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (flam_pkg::cfg_idx_t'(cfg_index))
                flam_pkg::REG_MIN_LEVEL:   cfg_next.min_level     = cfg_data;
                flam_pkg::REG_RESERVE:     cfg_next.reserve_level = cfg_data;
                flam_pkg::REG_OFF_LEVEL:   cfg_next.off_level     = cfg_data;
                flam_pkg::REG_SENSITIVITY:
                begin
                    cfg_next.step_sensitivity = cfg_data;
                    // The time-left compare needs 3600000 * sensitivity; it is
                    // formed here once per write instead of per reading.
                    cfg_next.eta_limit = flam_pkg::LIMIT_W'(cfg_data)
                                         * flam_pkg::LIMIT_W'(flam_pkg::ETA_LIMIT_MS);
                end
                flam_pkg::REG_ENABLE:      cfg_next.monitor_enable = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                  <= '0;
            cfg_reg.monitor_enable   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/flam_core.sv]
// Reading pipeline of the fuel level alarm monitor: input register, alarm
// evaluation with state update, and result register. Depends on flam_pkg.
`include "fuel_level_alarm_monitor_defines.svh"

module flam_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  flam_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [flam_pkg::LEVEL_W-1:0]      in_sum,
    input  logic [flam_pkg::TIME_W-1:0]       in_now,
    output logic                              out_valid,
    input  logic                              out_ready,
    output flam_pkg::result_t                 out_res
);

    localparam int unsigned LW = flam_pkg::LEVEL_W;
    localparam int unsigned TW = flam_pkg::TIME_W;

    // Input stage.
    logic          in_valid_reg;
    logic [LW-1:0] in_sum_reg;
    logic [TW-1:0] in_now_reg;

    // Monitor state.
    logic [LW-1:0] cur_level_reg,  cur_level_next;
    logic [LW-1:0] ref_level_reg,  ref_level_next;
    logic [TW-1:0] ref_time_reg,   ref_time_next;
    logic [TW-1:0] drop_int_reg,   drop_int_next;
    logic          low_flag_reg,   low_flag_next;
    logic          rate_flag_reg,  rate_flag_next;

    // Result stage.
    logic              out_valid_reg;
    flam_pkg::result_t out_res_reg, out_res_next;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Evaluation terms.
    logic [LW-1:0]                 prev, cur;
    logic [LW:0]                   cur_sens, ref_sens, res_sens;
    logic [LW+1:0]                 clear_lvl;
    logic                          retake, active, rate_act;
    logic                          drop, counted, upd_int;
    logic [TW-1:0]                 di_eff;
    logic [flam_pkg::SPAN_W-1:0]   span;
    logic                          time_short, low_fire, m_off;

    always_comb
    begin
        prev      = cur_level_reg;
        cur       = in_sum_reg;
        cur_sens  = {1'b0, cur} + {1'b0, cfg.step_sensitivity};
        ref_sens  = {1'b0, ref_level_reg} + {1'b0, cfg.step_sensitivity};
        res_sens  = {1'b0, cfg.reserve_level} + {1'b0, cfg.step_sensitivity};
        clear_lvl = {2'b00, cfg.min_level} + {1'b0, res_sens};

        retake   = (ref_level_reg == '0) || (ref_sens < {1'b0, cur});
        active   = cfg.monitor_enable && !retake;
        rate_act = active && (prev != '0);

        // A drop counts only when it exceeds the sensitivity strictly.
        drop     = {1'b0, prev} > cur_sens;
        counted  = rate_act && drop && !rate_flag_reg;
        upd_int  = counted && ({1'b0, ref_level_reg} > cur_sens);
        di_eff   = upd_int ? (in_now_reg - ref_time_reg) : drop_int_reg;

        rate_flag_next = rate_flag_reg;
        if (counted)
            rate_flag_next = 1'b1;
        else if (rate_act && ({1'b0, prev} < cur_sens))
            rate_flag_next = 1'b0;

        // Time left is short when (level - min) * interval <= 3600000 * sens.
        span       = flam_pkg::SPAN_W'(cur - cfg.min_level) * flam_pkg::SPAN_W'(di_eff);
        time_short = (cur != '0) && (di_eff != '0) && (cur >= cfg.min_level)
                     && (cfg.step_sensitivity != '0)
                     && (span <= flam_pkg::SPAN_W'(cfg.eta_limit));

        low_fire = active && !low_flag_reg
                   && (({1'b0, cur} < res_sens) || time_short);
        m_off    = active && !low_fire && (cur <= cfg.off_level);

        low_flag_next = low_flag_reg;
        if (low_fire)
            low_flag_next = 1'b1;
        else if (active && !m_off && ({2'b00, cur} >= clear_lvl))
            low_flag_next = 1'b0;

        cur_level_next = cur;
        ref_level_next = ref_level_reg;
        ref_time_next  = ref_time_reg;
        if ((cfg.monitor_enable && retake) || upd_int)
        begin
            ref_level_next = cur;
            ref_time_next  = in_now_reg;
        end
        drop_int_next = di_eff;

        out_res_next.level_out      = cur;
        out_res_next.rate_alarm     = counted;
        out_res_next.low_alarm      = low_fire;
        out_res_next.machine_off    = m_off;
        out_res_next.empty_interval = di_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_level_reg <= '0;
            ref_level_reg <= '0;
            ref_time_reg  <= '0;
            drop_int_reg  <= '0;
            low_flag_reg  <= 1'b0;
            rate_flag_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                cur_level_reg <= cur_level_next;
                ref_level_reg <= ref_level_next;
                ref_time_reg  <= ref_time_next;
                drop_int_reg  <= drop_int_next;
                low_flag_reg  <= low_flag_next;
                rate_flag_reg <= rate_flag_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_sum_reg <= in_sum;
            in_now_reg <= in_now;
        end
        if (advance)
            out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    `FLAM_ASSERT_NEXT(a_rate_sets_flag, clk, rst_n, advance && counted, rate_flag_reg)
    `FLAM_ASSERT_NOW(a_low_off_excl, clk, rst_n, out_valid_reg, !(out_res_reg.low_alarm && out_res_reg.machine_off))
    `FLAM_ASSERT_NEXT(a_disabled_quiet, clk, rst_n, advance && !cfg.monitor_enable, !out_res_reg.rate_alarm && !out_res_reg.low_alarm && !out_res_reg.machine_off)
    `FLAM_ASSERT_NEXT(a_result_drains, clk, rst_n, out_valid_reg && !out_ready && !advance, out_valid_reg)

endmodule

[hw/rtl/fuel_level_alarm_monitor.sv]
// Top level of the fuel level alarm monitor: stream ports, configuration
// port, and the packing of transfer data. Depends on flam_pkg, flam_cfg, flam_core.

// Each accepted reading produces exactly one result, in order. A reading is
// held in the input register while the evaluation logic feeds the result
// register; its result is registered there and then presented on the result
// stream. A new reading is accepted every cycle while the result side keeps
// up, limited only by the combinational state update (one 14x32 multiply and
// compare). Configuration writes take effect on the next clock edge and should
// be made while the block holds no readings in flight. There is no clearing
// pass after reset.
module fuel_level_alarm_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [13:0] sample_sum, [45:14] now_ms, [47:46] zero
    input  logic [47:0]                       s_tdata,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [13:0] level_out, [14] rate_alarm, [15] low_alarm, [16] machine_off,
    // [48:17] empty_interval, [55:49] zero
    output logic [55:0]                       m_tdata,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [flam_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [flam_pkg::CDATA_W-1:0]      cfg_data
);

    flam_pkg::cfg_t    cfg;
    flam_pkg::result_t res;

    flam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    flam_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sum    (s_tdata[13:0]),
        .in_now    (s_tdata[45:14]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'd0, res.empty_interval, res.machine_off, res.low_alarm,
                      res.rate_alarm, res.level_out};

endmodule

[tb/fuel_level_alarm_monitor_tb.sv]
// Self-checking testbench for fuel_level_alarm_monitor: drives tank readings on the
// input stream, predicts every result in-line and checks it on the result stream.
// Depends on flam_pkg and the fuel_level_alarm_monitor RTL only.
module fuel_level_alarm_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEVEL_MAX = 10230;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [13:0] sample_sum, [45:14] now_ms, [47:46] zero
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [13:0] level_out, [14] rate_alarm, [15] low_alarm, [16] machine_off,
    // [48:17] empty_interval, [55:49] zero
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [flam_pkg::CIDX_W-1:0]  cfg_index = '0;
    logic [flam_pkg::CDATA_W-1:0] cfg_data = '0;

    fuel_level_alarm_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies held by the predictor.
    int unsigned min_cfg = 0;
    int unsigned reserve_cfg = 0;
    int unsigned off_cfg = 0;
    int unsigned sens_cfg = 0;
    bit          enable_cfg = 1'b1;

    // Tank state held by the predictor.
    int unsigned lvl_now = 0;
    int unsigned lvl_prev = 0;
    int unsigned ref_lvl = 0;
    int unsigned ref_ms = 0;
    int unsigned drop_ms = 0;
    bit          low_latched = 1'b0;
    bit          rate_latched = 1'b0;

    flam_pkg::result_t pending_results[$];
    int      mismatches = 0;
    int      readings_sent = 0;
    int      results_checked = 0;
    int      cfg_phases = 0;
    int      burst_left = 0;
    int      tick = 0;
    int      stall_mode = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatches++;
        $display("[%0t] mismatch on %s: expected %0d, got %0d (result %0d)",
                 $realtime, what, want, got, results_checked);
    endtask

    // Advances the tank state by one reading and returns the result it should produce.
    function automatic flam_pkg::result_t predict_reading(input logic [13:0] sample,
                                                          input logic [31:0] now);
        flam_pkg::result_t r;
        int           cur_s;
        int           sens_s;
        int           drop;
        bit           counted;
        bit           eta_short;
        longint unsigned span;
        r = '0;
        lvl_prev = lvl_now;
        lvl_now = 32'(sample);
        cur_s = int'(lvl_now);
        sens_s = int'(sens_cfg);
        if (enable_cfg)
        begin
            if (ref_lvl == 0 || ref_lvl + sens_cfg < lvl_now)
            begin
                ref_lvl = lvl_now;
                ref_ms = now;
            end
            else
            begin
                if (lvl_prev != 0)
                begin
                    drop = int'(lvl_prev) - cur_s;
                    counted = 1'b0;
                    if (drop > sens_s && !rate_latched)
                    begin
                        r.rate_alarm = 1'b1;
                        rate_latched = 1'b1;
                        counted = 1'b1;
                    end
                    else if (drop < sens_s)
                        rate_latched = 1'b0;
                    // A counted drop far enough below the reference closes one interval.
                    if (counted && int'(ref_lvl) - cur_s > sens_s)
                    begin
                        drop_ms = now - ref_ms;
                        ref_lvl = lvl_now;
                        ref_ms = now;
                    end
                end
                // Time left is short when (level - min) * interval <= 60 min * sens.
                eta_short = 1'b0;
                if (lvl_now != 0 && drop_ms != 0 && lvl_now >= min_cfg && sens_cfg != 0)
                begin
                    span = longint'(lvl_now - min_cfg) * longint'(drop_ms);
                    eta_short = span <= longint'(flam_pkg::ETA_LIMIT_MS) * longint'(sens_cfg);
                end
                if (!low_latched && (cur_s < int'(reserve_cfg + sens_cfg) || eta_short))
                begin
                    r.low_alarm = 1'b1;
                    low_latched = 1'b1;
                end
                else if (lvl_now <= off_cfg)
                    r.machine_off = 1'b1;
                else if (lvl_now >= min_cfg + reserve_cfg + sens_cfg)
                    low_latched = 1'b0;
            end
        end
        r.level_out = lvl_now[13:0];
        r.empty_interval = drop_ms;
        return r;
    endfunction

    // Sends one reading; the sender runs in bursts, mostly separated by idle gaps.
    task automatic send_reading(input int unsigned sample, input logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, now, sample[13:0]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(predict_reading(sample[13:0], now));
        readings_sent++;
        burst_left--;
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input flam_pkg::cfg_idx_t idx, input logic [13:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            flam_pkg::REG_MIN_LEVEL:   min_cfg = 32'(value);
            flam_pkg::REG_RESERVE:     reserve_cfg = 32'(value);
            flam_pkg::REG_OFF_LEVEL:   off_cfg = 32'(value);
            flam_pkg::REG_SENSITIVITY: sens_cfg = 32'(value);
            flam_pkg::REG_ENABLE:      enable_cfg = value[0];
            default:                   ;
        endcase
    endtask

    // Rewrites every register once the block holds nothing in flight.
    task automatic program_regs(input int unsigned lo, input int unsigned reserve,
                                input int unsigned off, input int unsigned sens,
                                input int unsigned enable_word);
        settle_idle();
        write_reg(flam_pkg::REG_MIN_LEVEL, 14'(lo));
        write_reg(flam_pkg::REG_RESERVE, 14'(reserve));
        write_reg(flam_pkg::REG_OFF_LEVEL, 14'(off));
        write_reg(flam_pkg::REG_SENSITIVITY, 14'(sens));
        write_reg(flam_pkg::REG_ENABLE, 14'(enable_word));
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_phases++;
    endtask

    // Reset registers: zero sensitivity, timestamp wrap, level extremes.
    task automatic test_reset_registers();
        send_reading(0, 32'h0000_0000);
        send_reading(LEVEL_MAX, 32'hFFFF_FFFF);
        send_reading(LEVEL_MAX, 32'h0000_0005);
        send_reading(5000, 32'h0000_0064);
        send_reading(4000, 32'h0000_0100);
        send_reading(0, 32'h0000_00C8);
    endtask

    // Drops at, above and below sensitivity, rises, low alarm, off level, below minimum.
    task automatic test_drop_cases();
        program_regs(1000, 500, 1200, 100, 1);
        send_reading(8000, 32'd1000);
        send_reading(7900, 32'd2000);
        send_reading(7700, 32'd3000);
        send_reading(7500, 32'd4000);
        send_reading(7480, 32'd5000);
        send_reading(7700, 32'd6000);
        send_reading(7550, 32'd7000);
        send_reading(1550, 32'd8000);
        send_reading(590, 32'd9000);
        send_reading(580, 32'd10000);
        send_reading(3000, 32'd11000);
        send_reading(2950, 32'd12000);
        send_reading(900, 32'd13000);
    endtask

    // Monitoring off (only bit 0 of the enable word counts), then back on.
    task automatic test_monitor_off();
        program_regs(1000, 500, 1200, 100, 32'h3FFE);
        send_reading(6000, 32'd20000);
        send_reading(200, 32'd21000);
        send_reading(100, 32'd22000);
        program_regs(1000, 500, 1200, 100, 32'h3FFF);
        send_reading(50, 32'd23000);
    endtask

    // Draining-tank readings with random step sizes and intervals, plus some noise.
    task automatic random_drain(input int count);
        int          level;
        int unsigned sens_now;
        logic [31:0] now;
        int          pick;
        level = $urandom_range(6000, LEVEL_MAX);
        now = $urandom;
        sens_now = sens_cfg;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                level -= (sens_now > 0) ? $urandom_range(0, sens_now - 1) : 0;
            else if (pick < 58)
                level -= sens_now;
            else if (pick < 80)
                level -= sens_now + 1 + $urandom_range(0, 2 * sens_now + 20);
            else if (pick < 86)
                level += sens_now + 1 + $urandom_range(0, 500);
            else if (pick < 92)
                level = $urandom_range(0, LEVEL_MAX);
            if (level < 0)
                level = $urandom_range(0, 3);
            if (level > int'(LEVEL_MAX))
                level = LEVEL_MAX;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                now = $urandom;
            else if (pick != 1)
                now += $urandom_range(200, 45000);
            send_reading(level, now);
            // Refill an empty tank now and then so the drain starts over.
            if (level < 20 && $urandom_range(0, 3) == 0)
                level = $urandom_range(5000, LEVEL_MAX);
        end
    endtask

    task automatic test_random_phases();
        program_regs(1000, 800, 1100, 60, 1);
        random_drain(180);
        program_regs(0, 0, 0, 1, 1);
        random_drain(150);
        program_regs($urandom_range(0, 3000), $urandom_range(0, 2000),
                     $urandom_range(0, 4000), $urandom_range(1, 400), 1);
        random_drain(180);
        program_regs(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 1);
        random_drain(120);
        program_regs($urandom_range(0, 2000), $urandom_range(0, 1500),
                     $urandom_range(0, 3000), 0, 1);
        random_drain(140);
        program_regs($urandom_range(0, 2000), $urandom_range(0, 1500),
                     $urandom_range(0, 3000), $urandom_range(1, 200), 0);
        random_drain(80);
        program_regs(500, 300, 700, 40, 1);
        random_drain(200);
        program_regs($urandom_range(0, LEVEL_MAX), $urandom_range(0, LEVEL_MAX),
                     $urandom_range(0, LEVEL_MAX), $urandom_range(0, 1000),
                     $urandom_range(0, 16383));
        random_drain(200);
    endtask

    // Result side: checks every transfer and stalls on a changing pattern.
    always @(posedge clk)
    begin
        flam_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none expected", 0, m_tdata[13:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[13:0] !== want.level_out)
                    report_mismatch("level_out", want.level_out, m_tdata[13:0]);
                if (m_tdata[14] !== want.rate_alarm)
                    report_mismatch("rate_alarm", want.rate_alarm, m_tdata[14]);
                if (m_tdata[15] !== want.low_alarm)
                    report_mismatch("low_alarm", want.low_alarm, m_tdata[15]);
                if (m_tdata[16] !== want.machine_off)
                    report_mismatch("machine_off", want.machine_off, m_tdata[16]);
                if (m_tdata[48:17] !== want.empty_interval)
                    report_mismatch("empty_interval", want.empty_interval,
                                    m_tdata[48:17]);
            end
            results_checked++;
        end
        tick <= tick + 1;
        if (tick % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (tick % 5 < 3);
            default: m_tready <= ($urandom_range(0, 6) == 0);
        endcase
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_registers();
        test_drop_cases();
        test_monitor_off();
        test_random_phases();
        settle_idle();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("Sent %0d readings and checked %0d results across %0d register settings.",
                 readings_sent, results_checked, cfg_phases + 1);
        $display("Covered fast drops, low and off alarms, disabled monitoring and wrap.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/flam_pkg.sv
hw/rtl/flam_cfg.sv
hw/rtl/flam_core.sv
hw/rtl/fuel_level_alarm_monitor.sv
tb/fuel_level_alarm_monitor_tb.sv
